// ===== rtl/energy_meter_frame_decoder_defines.svh =====
// Assertion macros for the frame decoder.
`ifndef ENERGY_METER_FRAME_DECODER_DEFINES_SVH
`define ENERGY_METER_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EMFD_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define EMFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/emfd_pkg.sv =====
package emfd_pkg;

   localparam int FRAME_BYTES_DEFAULT = 24;

   localparam int COEFF_W = 18;
   localparam logic [COEFF_W-1:0] COEFF_RESET = 18'd123208;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_COEFF = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_COEFF   = 1'd1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CHIP_ERR  = 2'd1;
   localparam logic [1:0] STATUS_BAD_FRAME = 2'd2;

   localparam logic [7:0] HEADER_BYTE   = 8'h5a;
   localparam logic [7:0] CHIP_ERR_BYTE = 8'haa;
   localparam logic [7:0] OVF_LIMIT     = 8'hf0;
   localparam int UPDATE_BIT = 7;

   // byte positions within a frame
   localparam int FLAG_AT  = 0;
   localparam int HDR_AT   = 1;
   localparam int VNUM_AT  = 2;
   localparam int VDEN_AT  = 5;
   localparam int CNUM_AT  = 8;
   localparam int CDEN_AT  = 11;
   localparam int PNUM_AT  = 14;
   localparam int PDEN_AT  = 17;
   localparam int UPD_AT   = 20;
   localparam int PULSE_AT = 21;

   localparam int REG_W    = 24;
   localparam int CENTI_W  = 31;
   localparam int SCALED_W = REG_W + COEFF_W;
   localparam int TOGGLE_W = 8;
   localparam int PULSE_W  = TOGGLE_W + 16;

   localparam logic [REG_W-1:0]   Q24_MAX   = '1;
   localparam logic [CENTI_W-1:0] CENTI_MAX = 31'd1677721500;

   localparam int DIV_NUM_W       = 32;
   localparam int DIV_STEPS_LONG  = DIV_NUM_W / 2;
   localparam int DIV_STEPS_SHORT = REG_W / 2;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS_LONG + 1);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [SCALED_W-1:0] voltage_scaled;
      logic [CENTI_W-1:0]  current_centi;
      logic [SCALED_W-1:0] power_scaled;
      logic                power_overflow;
      logic [PULSE_W-1:0]  pulse_count;
      logic                divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic long_op;
   } div_ctl_type;

endpackage

// ===== rtl/emfd_div.sv =====
module emfd_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  emfd_pkg::div_ctl_type                   ctl,
   input  logic [emfd_pkg::DIV_NUM_W-1:0]          numer,
   input  logic [emfd_pkg::REG_W-1:0]              denom,
   output logic                                    done,
   output logic [emfd_pkg::DIV_NUM_W-1:0]          quot
);

   localparam int NW = emfd_pkg::DIV_NUM_W;
   localparam int DW = emfd_pkg::REG_W;
   localparam int CW = emfd_pkg::DIV_CNT_W;
   localparam int SHORT_PAD = NW - 2 * emfd_pkg::DIV_STEPS_SHORT;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] quot_ff, quot_in;

   logic [DW:0] t1, r1, t2, r2;
   logic        ge1, ge2;

   // two restoring steps per cycle
   assign t1  = {rem_ff, dvd_ff[NW-1]};
   assign ge1 = t1 >= {1'b0, den_ff};
   assign r1  = ge1 ? (t1 - {1'b0, den_ff}) : t1;
   assign t2  = {r1[DW-1:0], dvd_ff[NW-2]};
   assign ge2 = t2 >= {1'b0, den_ff};
   assign r2  = ge2 ? (t2 - {1'b0, den_ff}) : t2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         den_in  = denom;
         quot_in = '0;
         if (ctl.long_op) begin
            dvd_in = numer;
            cnt_in = CW'(emfd_pkg::DIV_STEPS_LONG);
         end else begin
            dvd_in = {numer[NW-SHORT_PAD-1:0], {SHORT_PAD{1'b0}}};
            cnt_in = CW'(emfd_pkg::DIV_STEPS_SHORT);
         end
      end else if (busy_ff) begin
         rem_in  = r2[DW-1:0];
         dvd_in  = {dvd_ff[NW-3:0], 2'b00};
         quot_in = {quot_ff[NW-3:0], ge1, ge2};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/energy_meter_frame_decoder.sv =====
// Frame decoder for a metering chip's serial frame. A request flagged frame_end closes
// the frame and yields exactly one response. A bad length or header gives status 2, a
// chip error byte status 1, once the response register is free after the closing request.
// A good frame is decoded by one shared restoring divider that retires two quotient bits
// a cycle (12 steps for voltage and power, 16 for current) and one 24x18 multiplier; a
// zero divisor or a power overflow skips the divider work that it would need.
// req_ready is low while a frame is being decoded; bytes of a new frame are accepted
// while an earlier response still waits. Coefficients are written through the csr
// port (index 0 voltage, 1 power, Q2.16) and should be changed only while idle.
`include "energy_meter_frame_decoder_defines.svh"

module energy_meter_frame_decoder #(
   parameter int FRAME_BYTES = emfd_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  emfd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output emfd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [emfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [emfd_pkg::COEFF_W-1:0]         csr_wdata
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam int RW = emfd_pkg::REG_W;
   localparam int NW = emfd_pkg::DIV_NUM_W;
   localparam int CENTI_W = emfd_pkg::CENTI_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_WAIT   = 4'd1;
   localparam logic [3:0] ST_VSTART = 4'd2;
   localparam logic [3:0] ST_VWAIT  = 4'd3;
   localparam logic [3:0] ST_VMUL   = 4'd4;
   localparam logic [3:0] ST_CSTART = 4'd5;
   localparam logic [3:0] ST_CWAIT  = 4'd6;
   localparam logic [3:0] ST_PSTART = 4'd7;
   localparam logic [3:0] ST_PWAIT  = 4'd8;
   localparam logic [3:0] ST_PMUL   = 4'd9;
   localparam logic [3:0] ST_FIN    = 4'd10;

   logic [3:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    byte_idx_ff, byte_idx_in;
   logic                                overlong_ff, overlong_in;
   logic [emfd_pkg::TOGGLE_W-1:0]       toggle_ff, toggle_in;
   logic                                last_upd_ff, last_upd_in;
   logic [emfd_pkg::COEFF_W-1:0]        vcoeff_ff, vcoeff_in;
   logic [emfd_pkg::COEFF_W-1:0]        pcoeff_ff, pcoeff_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [7:0]                          store_ff [FRAME_BYTES];
   logic [7:0]                          store_in [FRAME_BYTES];
   logic [1:0]                          status_ff, status_in;
   logic [RW-1:0]                       q_ff, q_in;
   emfd_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                frame_good;
   logic                                rsp_free;
   logic                                upd_bit;
   logic [RW-1:0]                       vnum, vden, cnum, cden, pnum, pden;
   logic [CENTI_W-1:0]                  cnum_x100;
   logic [emfd_pkg::COEFF_W-1:0]        mul_coeff;
   logic [emfd_pkg::SCALED_W-1:0]       product;
   emfd_pkg::div_ctl_type               div_ctl;
   logic [NW-1:0]                       div_numer;
   logic [RW-1:0]                       div_denom;
   logic                                div_done;
   logic [NW-1:0]                       div_quot;

   assign vnum = {store_ff[emfd_pkg::VNUM_AT], store_ff[emfd_pkg::VNUM_AT+1],
                  store_ff[emfd_pkg::VNUM_AT+2]};
   assign vden = {store_ff[emfd_pkg::VDEN_AT], store_ff[emfd_pkg::VDEN_AT+1],
                  store_ff[emfd_pkg::VDEN_AT+2]};
   assign cnum = {store_ff[emfd_pkg::CNUM_AT], store_ff[emfd_pkg::CNUM_AT+1],
                  store_ff[emfd_pkg::CNUM_AT+2]};
   assign cden = {store_ff[emfd_pkg::CDEN_AT], store_ff[emfd_pkg::CDEN_AT+1],
                  store_ff[emfd_pkg::CDEN_AT+2]};
   assign pnum = {store_ff[emfd_pkg::PNUM_AT], store_ff[emfd_pkg::PNUM_AT+1],
                  store_ff[emfd_pkg::PNUM_AT+2]};
   assign pden = {store_ff[emfd_pkg::PDEN_AT], store_ff[emfd_pkg::PDEN_AT+1],
                  store_ff[emfd_pkg::PDEN_AT+2]};

   // x100 = x64 + x32 + x4
   assign cnum_x100 = ({{(CENTI_W-RW){1'b0}}, cnum} << 6)
                    + ({{(CENTI_W-RW){1'b0}}, cnum} << 5)
                    + ({{(CENTI_W-RW){1'b0}}, cnum} << 2);

   assign frame_good = !overlong_ff && (byte_idx_ff == LAST_IDX);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign upd_bit    = store_ff[emfd_pkg::UPD_AT][emfd_pkg::UPDATE_BIT];

   assign mul_coeff = (state_ff == ST_PMUL) ? pcoeff_ff : vcoeff_ff;
   assign product   = {{emfd_pkg::COEFF_W{1'b0}}, q_ff} * {{RW{1'b0}}, mul_coeff};

   emfd_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      byte_idx_in  = byte_idx_ff;
      overlong_in  = overlong_ff;
      toggle_in    = toggle_ff;
      last_upd_in  = last_upd_ff;
      vcoeff_in    = vcoeff_ff;
      pcoeff_in    = pcoeff_ff;
      rsp_valid_in = rsp_valid_ff;
      store_in     = store_ff;
      status_in    = status_ff;
      q_in         = q_ff;
      rsp_data_in  = rsp_data_ff;
      div_ctl      = '0;
      div_numer    = {{(NW-RW){1'b0}}, vnum};
      div_denom    = vden;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            emfd_pkg::CSR_VOLTAGE_COEFF: vcoeff_in = csr_wdata;
            emfd_pkg::CSR_POWER_COEFF:   pcoeff_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_data.frame_end) begin
                  if (!overlong_ff) begin
                     store_in[byte_idx_ff] = req_data.rx_byte;
                     if (byte_idx_ff == LAST_IDX) begin
                        overlong_in = 1'b1;
                     end else begin
                        byte_idx_in = byte_idx_ff + 1'b1;
                     end
                  end
               end else begin
                  if (frame_good) begin
                     store_in[byte_idx_ff] = req_data.rx_byte;
                  end
                  byte_idx_in = '0;
                  overlong_in = 1'b0;
                  if (!frame_good || store_ff[emfd_pkg::HDR_AT] != emfd_pkg::HEADER_BYTE) begin
                     status_in = emfd_pkg::STATUS_BAD_FRAME;
                  end else if (store_ff[emfd_pkg::FLAG_AT] == emfd_pkg::CHIP_ERR_BYTE) begin
                     status_in = emfd_pkg::STATUS_CHIP_ERR;
                  end else begin
                     status_in = emfd_pkg::STATUS_OK;
                  end
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (rsp_free) begin
               rsp_data_in        = '0;
               rsp_data_in.status = status_ff;
               if (status_ff != emfd_pkg::STATUS_OK) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_VSTART;
               end
            end
         end
         ST_VSTART: begin
            if (vden == '0) begin
               q_in                       = emfd_pkg::Q24_MAX;
               rsp_data_in.divide_by_zero = 1'b1;
               state_in                   = ST_VMUL;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = ST_VWAIT;
            end
         end
         ST_VWAIT: begin
            if (div_done) begin
               q_in     = div_quot[RW-1:0];
               state_in = ST_VMUL;
            end
         end
         ST_VMUL: begin
            rsp_data_in.voltage_scaled = product;
            state_in                   = ST_CSTART;
         end
         ST_CSTART: begin
            div_numer = {{(NW-CENTI_W){1'b0}}, cnum_x100};
            div_denom = cden;
            if (cden == '0) begin
               rsp_data_in.current_centi  = emfd_pkg::CENTI_MAX;
               rsp_data_in.divide_by_zero = 1'b1;
               state_in                   = ST_PSTART;
            end else begin
               div_ctl.start   = 1'b1;
               div_ctl.long_op = 1'b1;
               state_in        = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (div_done) begin
               rsp_data_in.current_centi = div_quot[CENTI_W-1:0];
               state_in                  = ST_PSTART;
            end
         end
         ST_PSTART: begin
            div_numer = {{(NW-RW){1'b0}}, pnum};
            div_denom = pden;
            if (store_ff[emfd_pkg::FLAG_AT] > emfd_pkg::OVF_LIMIT) begin
               rsp_data_in.power_overflow = 1'b1;
               state_in                   = ST_FIN;
            end else if (pden == '0) begin
               q_in                       = emfd_pkg::Q24_MAX;
               rsp_data_in.divide_by_zero = 1'b1;
               state_in                   = ST_PMUL;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = ST_PWAIT;
            end
         end
         ST_PWAIT: begin
            if (div_done) begin
               q_in     = div_quot[RW-1:0];
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            rsp_data_in.power_scaled = product;
            state_in                 = ST_FIN;
         end
         ST_FIN: begin
            if (upd_bit != last_upd_ff) begin
               toggle_in   = toggle_ff + 1'b1;
               last_upd_in = upd_bit;
            end
            rsp_data_in.pulse_count = {toggle_in, store_ff[emfd_pkg::PULSE_AT],
                                       store_ff[emfd_pkg::PULSE_AT+1]};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_idx_ff  <= '0;
         overlong_ff  <= 1'b0;
         toggle_ff    <= '0;
         last_upd_ff  <= 1'b0;
         vcoeff_ff    <= emfd_pkg::COEFF_RESET;
         pcoeff_ff    <= emfd_pkg::COEFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_idx_ff  <= byte_idx_in;
         overlong_ff  <= overlong_in;
         toggle_ff    <= toggle_in;
         last_upd_ff  <= last_upd_in;
         vcoeff_ff    <= vcoeff_in;
         pcoeff_ff    <= pcoeff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff    <= store_in;
      status_ff   <= status_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EMFD_ASSERT(a_div_done_in_wait, div_done, state_ff == ST_VWAIT || state_ff == ST_CWAIT || state_ff == ST_PWAIT, "divider done outside a wait state")
   `EMFD_ASSERT(a_overlong_at_last, overlong_ff, byte_idx_ff == LAST_IDX, "overlong frame with index short of last byte")
   `EMFD_ASSERT(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN || $past(state_ff) == ST_WAIT, "response raised outside frame close")
   `EMFD_ASSERT_NEXT(a_end_leaves_idle, req_valid && req_ready && req_data.frame_end, state_ff == ST_WAIT, "frame end request did not start decode")

endmodule

// ===== test/energy_meter_frame_decoder_test.sv =====
module energy_meter_frame_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import emfd_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int FRAME_LEN      = FRAME_BYTES_DEFAULT;
   localparam int DRAFT_LEN      = 40;
   localparam int MAX_WAIT       = 10;
   localparam int PHASES         = 6;
   localparam int PHASE_BYTES    = 250;
   localparam int PRESSURE_PHASE = 3;
   localparam int HOLD_CYCLES    = 1500;
   localparam int SETTLE_CYCLES  = 100;
   localparam int QUIET_LIMIT    = 5000;
   localparam int REPORT_LIMIT   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEFF_W-1:0]   csr_wdata = '0;

   energy_meter_frame_decoder #(.FRAME_BYTES(FRAME_LEN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // meter decoder state as the testbench tracks it
   logic [7:0]         frame_bytes [0:31];
   logic [4:0]         frame_pos;
   logic               frame_overlong;
   logic [7:0]         update_toggles;
   logic               last_update;
   logic [COEFF_W-1:0] volt_coeff = COEFF_RESET;
   logic [COEFF_W-1:0] pwr_coeff  = COEFF_RESET;

   req_type byte_backlog [$];
   rsp_type expected_readings [$];

   logic [7:0] draft [0:DRAFT_LEN-1];
   int queued_bytes;
   int send_gap_max = MAX_WAIT;
   int stall_max    = MAX_WAIT;
   int send_gap;
   int stall_left;
   int hold_left;
   logic hold_off_request = 1'b0;
   logic hold_off_done;
   int quiet_cycles;
   int mismatches;
   int bytes_taken, frames_decoded, frames_chip_err, frames_rejected;
   int overflow_frames, div_zero_frames, coeff_settings;

   function automatic logic [REG_W-1:0] stored_reg(input int at);
      return {frame_bytes[at], frame_bytes[at + 1], frame_bytes[at + 2]};
   endfunction

   function automatic logic [REG_W-1:0] stored_quotient(input int at, inout logic dz);
      logic [REG_W-1:0] num, den;
      num = stored_reg(at);
      den = stored_reg(at + 3);
      if (den == '0) begin
         dz = 1'b1;
         return Q24_MAX;
      end
      return num / den;
   endfunction

   function automatic void take_byte(input req_type r);
      rsp_type          exp;
      logic             good, dz, upd;
      logic [REG_W-1:0] vq, pq, cp, cr;
      logic [31:0]      centi;
      exp = '0;
      dz  = 1'b0;
      if (!r.frame_end) begin
         if (!frame_overlong) begin
            frame_bytes[frame_pos] = r.rx_byte;
            if (frame_pos >= FRAME_LEN - 1) frame_overlong = 1'b1;
            else frame_pos = frame_pos + 1'b1;
         end
         return;
      end
      good = !frame_overlong && frame_pos == FRAME_LEN - 1;
      if (good) frame_bytes[frame_pos] = r.rx_byte;
      frame_pos      = '0;
      frame_overlong = 1'b0;
      if (!good || frame_bytes[HDR_AT] != HEADER_BYTE) begin
         exp.status = STATUS_BAD_FRAME;
         frames_rejected++;
      end else if (frame_bytes[FLAG_AT] == CHIP_ERR_BYTE) begin
         exp.status = STATUS_CHIP_ERR;
         frames_chip_err++;
      end else begin
         exp.status = STATUS_OK;
         vq = stored_quotient(VNUM_AT, dz);
         exp.voltage_scaled = {18'd0, vq} * {24'd0, volt_coeff};
         cp = stored_reg(CNUM_AT);
         cr = stored_reg(CDEN_AT);
         if (cr == '0) begin
            dz = 1'b1;
            exp.current_centi = CENTI_MAX;
         end else begin
            centi = {8'd0, cp} * 32'd100;
            centi = centi / {8'd0, cr};
            exp.current_centi = centi[CENTI_W-1:0];
         end
         if (frame_bytes[FLAG_AT] > OVF_LIMIT) begin
            exp.power_overflow = 1'b1;
            overflow_frames++;
         end else begin
            pq = stored_quotient(PNUM_AT, dz);
            exp.power_scaled = {18'd0, pq} * {24'd0, pwr_coeff};
         end
         upd = frame_bytes[UPD_AT][UPDATE_BIT];
         if (upd != last_update) begin
            update_toggles = update_toggles + 1'b1;
            last_update    = upd;
         end
         exp.pulse_count    = {update_toggles, frame_bytes[PULSE_AT], frame_bytes[PULSE_AT + 1]};
         exp.divide_by_zero = dz;
         if (dz) div_zero_frames++;
         frames_decoded++;
      end
      expected_readings.push_back(exp);
   endfunction

   // request driver and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         for (int i = 0; i < 32; i++) frame_bytes[i] = '0;
         frame_pos      = '0;
         frame_overlong = 1'b0;
         update_toggles = '0;
         last_update    = 1'b0;
         expected_readings.delete();
      end else begin
         if (req_valid && req_ready) begin
            take_byte(req_data);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               req_data  <= byte_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = $urandom_range(0, send_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endtask

   // response monitor
   always @(posedge clock) begin : rsp_side
      logic    ready_next;
      rsp_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left    = 0;
         hold_left     = 0;
         hold_off_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               flag_mismatch("unexpected response, status", '0, 64'(rsp_data.status));
            end else begin
               exp = expected_readings.pop_front();
               if (rsp_data.status !== exp.status)
                  flag_mismatch("status", 64'(exp.status), 64'(rsp_data.status));
               if (rsp_data.voltage_scaled !== exp.voltage_scaled)
                  flag_mismatch("voltage_scaled", 64'(exp.voltage_scaled),
                                64'(rsp_data.voltage_scaled));
               if (rsp_data.current_centi !== exp.current_centi)
                  flag_mismatch("current_centi", 64'(exp.current_centi),
                                64'(rsp_data.current_centi));
               if (rsp_data.power_scaled !== exp.power_scaled)
                  flag_mismatch("power_scaled", 64'(exp.power_scaled),
                                64'(rsp_data.power_scaled));
               if (rsp_data.power_overflow !== exp.power_overflow)
                  flag_mismatch("power_overflow", 64'(exp.power_overflow),
                                64'(rsp_data.power_overflow));
               if (rsp_data.pulse_count !== exp.pulse_count)
                  flag_mismatch("pulse_count", 64'(exp.pulse_count),
                                64'(rsp_data.pulse_count));
               if (rsp_data.divide_by_zero !== exp.divide_by_zero)
                  flag_mismatch("divide_by_zero", 64'(exp.divide_by_zero),
                                64'(rsp_data.divide_by_zero));
            end
         end
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            stall_left = $urandom_range(0, stall_max);
            ready_next = stall_left == 0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = stall_left == 0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
         $display("energy_meter_frame_decoder_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void put24(input int at, input logic [REG_W-1:0] value);
      {draft[at], draft[at + 1], draft[at + 2]} = value;
   endfunction

   function automatic void blank_frame();
      for (int i = 0; i < DRAFT_LEN; i++) draft[i] = '0;
      draft[HDR_AT] = HEADER_BYTE;
   endfunction

   function automatic void queue_draft(input int len);
      req_type r;
      for (int i = 0; i < len; i++) begin
         r.rx_byte   = draft[i];
         r.frame_end = i == len - 1;
         byte_backlog.push_back(r);
      end
      queued_bytes += (len < FRAME_LEN) ? len : FRAME_LEN;
   endfunction

   function automatic void shape_pair(input int at);
      logic [REG_W-1:0] num, den;
      num = REG_W'($urandom_range(0, 24'hffffff));
      den = REG_W'($urandom_range(0, 24'hffffff));
      case ($urandom_range(0, 7))
         0: den = '0;
         1: num = '1;
         2, 3: den = REG_W'($urandom_range(1, 255));
         4: begin
            num = '1;
            den = REG_W'(1);
         end
         default: ;
      endcase
      put24(at, num);
      put24(at + 3, den);
   endfunction

   function automatic int draft_random_frame();
      int kind, len;
      kind = $urandom_range(0, 19);
      len  = FRAME_LEN;
      for (int i = 0; i < DRAFT_LEN; i++) draft[i] = 8'($urandom_range(0, 255));
      if (kind < 15) begin
         draft[HDR_AT] = HEADER_BYTE;
         case ($urandom_range(0, 4))
            0: draft[FLAG_AT] = 8'($urandom_range(OVF_LIMIT + 1, 255));
            1: ;
            default: draft[FLAG_AT] = 8'($urandom_range(0, OVF_LIMIT));
         endcase
         if (kind == 0) draft[FLAG_AT] = CHIP_ERR_BYTE;
         shape_pair(VNUM_AT);
         shape_pair(CNUM_AT);
         shape_pair(PNUM_AT);
      end else if (kind < 17) begin
         if (draft[HDR_AT] == HEADER_BYTE) draft[HDR_AT][0] = ~draft[HDR_AT][0];
      end else if (kind == 17) begin
         draft[HDR_AT] = HEADER_BYTE;
         len = $urandom_range(1, FRAME_LEN - 1);
      end else if (kind == 18) begin
         draft[HDR_AT] = HEADER_BYTE;
         len = $urandom_range(FRAME_LEN + 1, DRAFT_LEN);
      end
      return len;
   endfunction

   task automatic write_coeff(input logic [CSR_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_VOLTAGE_COEFF) volt_coeff = val;
      else pwr_coeff = val;
      coeff_settings++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [COEFF_W-1:0] vset, pset;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // largest quotients, update bit set
      blank_frame();
      put24(VNUM_AT, '1);
      put24(VDEN_AT, REG_W'(1));
      put24(CNUM_AT, '1);
      put24(CDEN_AT, REG_W'(1));
      put24(PNUM_AT, '1);
      put24(PDEN_AT, REG_W'(1));
      draft[UPD_AT]       = 8'h80;
      draft[PULSE_AT]     = 8'hff;
      draft[PULSE_AT + 1] = 8'hff;
      queue_draft(FRAME_LEN);
      // every divisor zero, flag byte right at the overflow limit
      blank_frame();
      draft[FLAG_AT] = OVF_LIMIT;
      put24(VNUM_AT, REG_W'(5));
      put24(CNUM_AT, REG_W'(5));
      put24(PNUM_AT, REG_W'(5));
      queue_draft(FRAME_LEN);
      // power overflow hides a zero power divisor
      blank_frame();
      draft[FLAG_AT] = OVF_LIMIT + 8'd1;
      put24(VNUM_AT, '1);
      put24(VDEN_AT, REG_W'(3));
      put24(CNUM_AT, REG_W'(12345));
      put24(CDEN_AT, REG_W'(7));
      draft[UPD_AT] = 8'h80;
      queue_draft(FRAME_LEN);
      // overflow with zero voltage divisor
      blank_frame();
      draft[FLAG_AT] = 8'hff;
      put24(CDEN_AT, REG_W'(1));
      queue_draft(FRAME_LEN);
      // quotients truncate to zero
      blank_frame();
      put24(VNUM_AT, REG_W'(5));
      put24(VDEN_AT, '1);
      put24(CNUM_AT, REG_W'(1));
      put24(CDEN_AT, '1);
      put24(PNUM_AT, REG_W'(2));
      put24(PDEN_AT, REG_W'(3));
      queue_draft(FRAME_LEN);
      // chip error, wrong header, short, single byte, overlong frames
      blank_frame();
      draft[FLAG_AT] = CHIP_ERR_BYTE;
      put24(VDEN_AT, REG_W'(1));
      queue_draft(FRAME_LEN);
      blank_frame();
      draft[HDR_AT] = ~HEADER_BYTE;
      queue_draft(FRAME_LEN);
      blank_frame();
      queue_draft(FRAME_LEN - 1);
      queue_draft(1);
      queue_draft(FRAME_LEN + 1);
      queue_draft(DRAFT_LEN);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               vset = '1;
               pset = '1;
            end
            1: begin
               vset = '0;
               pset = '0;
            end
            4: begin
               vset = '0;
               pset = '1;
            end
            default: begin
               vset = COEFF_W'($urandom_range(0, 2**COEFF_W - 1));
               pset = COEFF_W'($urandom_range(0, 2**COEFF_W - 1));
            end
         endcase
         write_coeff(CSR_VOLTAGE_COEFF, vset);
         write_coeff(CSR_POWER_COEFF, pset);
         @(negedge clock);
         send_gap_max = (phase % 3 == 0) ? 0 : MAX_WAIT;
         stall_max    = (phase % 3 == 0) ? 0 : MAX_WAIT;
         queued_bytes = 0;
         while (queued_bytes < PHASE_BYTES) queue_draft(draft_random_frame());
         // long response hold-off so the decoder backs up into req_ready
         if (phase == PRESSURE_PHASE) hold_off_request <= 1'b1;
         wait_idle();
      end

      $display("%0d request bytes, %0d frames decoded (%0d power overflow, %0d divide by zero),",
               bytes_taken, frames_decoded, overflow_frames, div_zero_frames);
      $display("%0d chip error, %0d rejected; %0d coefficient writes incl. extremes",
               frames_chip_err, frames_rejected, coeff_settings);
      if (mismatches == 0) begin
         $display("energy_meter_frame_decoder_test: PASS");
      end else begin
         $display("energy_meter_frame_decoder_test: FAIL");
      end
      $finish;
   end

endmodule
